// ----- hw/rtl/gwm_pkg.sv -----
package gwm_pkg;

    typedef enum logic [1:0] {
        CMD_CLEAR   = 2'd0,
        CMD_APPEND  = 2'd1,
        CMD_SUBJECT = 2'd2,
        CMD_FINISH  = 2'd3
    } cmd_t;

    localparam logic [7:0] CH_ANY  = 8'h3F;
    localparam logic [7:0] CH_STAR = 8'h2A;

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 8;

endpackage

// ----- hw/rtl/gwm_pattern_store.sv -----
module gwm_pattern_store #(
    parameter int PATTERN_MAX = 64,
    parameter int LEN_W       = 7
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  gwm_pkg::cmd_t          command,
    input  logic [7:0]             char_value,
    output logic [PATTERN_MAX-1:0] star_vec,
    output logic [PATTERN_MAX-1:0] hit_vec,
    output logic [LEN_W-1:0]       length,
    output logic                   overflow
);
    import gwm_pkg::*;

    logic [7:0]             store_reg [PATTERN_MAX];
    logic [LEN_W-1:0]       len_reg;
    logic                   ovf_reg;
    logic [PATTERN_MAX-1:0] lane_en;
    logic                   append;

    assign append = step && (command == CMD_APPEND);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else if (step && (command == CMD_CLEAR))
        begin
            len_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else if (append)
        begin
            if (len_reg < LEN_W'(PATTERN_MAX))
                len_reg <= len_reg + LEN_W'(1);
            else
                ovf_reg <= 1'b1;
        end
    end

    // Each position has its own byte register, written when it is the next free slot.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < PATTERN_MAX; i++)
        begin
            if (append && (len_reg == LEN_W'(i)))
                store_reg[i] <= char_value;
        end
    end

    always_comb
    begin
        for (int i = 0; i < PATTERN_MAX; i++)
        begin
            lane_en[i]  = LEN_W'(i) < len_reg;
            star_vec[i] = lane_en[i] && (store_reg[i] == CH_STAR);
            // A star lane never consumes a byte as a single match.
            hit_vec[i]  = lane_en[i] && (store_reg[i] != CH_STAR)
                          && ((store_reg[i] == CH_ANY) || (store_reg[i] == char_value));
        end
    end

    assign length   = len_reg;
    assign overflow = ovf_reg;

endmodule

// ----- hw/rtl/gwm_active_vector.sv -----
module gwm_active_vector #(
    parameter int PATTERN_MAX = 64,
    parameter int LEN_W       = 7
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  gwm_pkg::cmd_t          command,
    input  logic [PATTERN_MAX-1:0] star_vec,
    input  logic [PATTERN_MAX-1:0] hit_vec,
    input  logic [LEN_W-1:0]       length,
    output logic                   end_active
);
    import gwm_pkg::*;

    localparam int VEC_W = PATTERN_MAX + 1;
    localparam logic [VEC_W-1:0] START = VEC_W'(1);

    logic [VEC_W-1:0] active_reg;
    logic [VEC_W-1:0] active_next;
    logic [VEC_W-1:0] star_ext;
    logic [VEC_W-1:0] closed;
    logic [VEC_W-1:0] fed;

    // Star closure as a carry chain: a star propagates activity to the next position,
    // an active star generates it. The carries of one add give the whole closure.
    assign star_ext = {1'b0, star_vec};
    assign closed   = active_reg
                      | ((star_ext + (active_reg & star_ext)) ^ (star_ext & ~active_reg));

    assign fed = {closed[PATTERN_MAX-1:0] & hit_vec, 1'b0}
                 | {1'b0, closed[PATTERN_MAX-1:0] & star_vec};

    assign end_active = closed[length];

    always_comb
    begin
        active_next = active_reg;
        if (step)
        begin
            case (command)
                CMD_SUBJECT: active_next = fed;
                default:     active_next = START;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            active_reg <= START;
        else
            active_reg <= active_next;
    end

endmodule

// ----- hw/rtl/glob_wildcard_matcher.sv -----
// Path: a finish word goes from the input register to the result register, and it
// waits in the input register while the result register holds a result not yet taken.
// Throughput: one word per cycle while results are taken; each subject byte
// updates all pattern positions at once.
// Reset (rst_n low, asynchronous) empties the pattern, clears the overflow flag,
// leaves only position zero active and drops any word in flight.
module glob_wildcard_matcher #(
    parameter int PATTERN_MAX = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [1:0] command, [9:2] char_value, [15:10] zero
    input  logic [gwm_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [0] matched, [1] pattern_overflow, [7:2] zero
    output logic [gwm_pkg::M_TDATA_W-1:0]   m_tdata
);
    import gwm_pkg::*;

    localparam int LEN_W = $clog2(PATTERN_MAX + 1);

    logic                   in_valid_reg;
    cmd_t                   cmd_reg;
    logic [7:0]             char_reg;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic                   matched_reg;
    logic                   ovf_out_reg;
    logic                   step;
    logic                   accept;
    logic [PATTERN_MAX-1:0] star_vec;
    logic [PATTERN_MAX-1:0] hit_vec;
    logic [LEN_W-1:0]       length;
    logic                   overflow;
    logic                   end_active;

    // Only a finish word needs room in the result register.
    assign step     = in_valid_reg && ((cmd_reg != CMD_FINISH) || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || step;
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg  <= cmd_t'(s_tdata[1:0]);
            char_reg <= s_tdata[9:2];
        end
    end

    gwm_pattern_store #(
        .PATTERN_MAX (PATTERN_MAX),
        .LEN_W       (LEN_W)
    ) u_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .command    (cmd_reg),
        .char_value (char_reg),
        .star_vec   (star_vec),
        .hit_vec    (hit_vec),
        .length     (length),
        .overflow   (overflow)
    );

    gwm_active_vector #(
        .PATTERN_MAX (PATTERN_MAX),
        .LEN_W       (LEN_W)
    ) u_active (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .command    (cmd_reg),
        .star_vec   (star_vec),
        .hit_vec    (hit_vec),
        .length     (length),
        .end_active (end_active)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg && !m_tready;
        if (step && (cmd_reg == CMD_FINISH))
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (step && (cmd_reg == CMD_FINISH))
        begin
            matched_reg <= end_active && !overflow;
            ovf_out_reg <= overflow;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, ovf_out_reg, matched_reg};

endmodule
